@@ hdl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define AST_RST(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error("assertion failed");

// Checked at every edge, reset included.
`define AST_ANY(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

@@ hdl/mrvd_pkg.sv @@
package mrvd_pkg;

  localparam int RAW_W  = 32;
  localparam int EXP_W  = 5;
  localparam int TAG_W  = 8;
  localparam int VAL_W  = 32;
  localparam int OPND_W = 32;
  localparam int POW_W  = 30;
  localparam int PROD_W = 62;
  localparam int DIVD_W = 60;
  localparam int REM_W  = 30;
  localparam int DIV_BPS    = 4;
  localparam int DIV_STAGES = DIVD_W / DIV_BPS;
  localparam int T_W    = 64;
  localparam int RP_W   = 6;
  localparam int SH_W   = 10;
  localparam int RND_W  = 25;

  typedef enum logic [1:0] {
    FMT_INT16   = 2'd0,
    FMT_INT32   = 2'd1,
    FMT_FLOAT32 = 2'd2,
    FMT_NONE    = 2'd3
  } fmt_t;

  typedef enum logic [1:0] {
    ORD_LB_LW = 2'd0,
    ORD_LB_HW = 2'd1,
    ORD_HB_LW = 2'd2,
    ORD_HB_HW = 2'd3
  } ord_t;

  localparam logic CFG_FORMAT = 1'b0;
  localparam logic CFG_ORDER  = 1'b1;

  typedef enum logic [2:0] {
    K_INVALID,
    K_ZERO,
    K_IDIV,
    K_IMUL,
    K_FDIV,
    K_FMUL
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic              neg;
    logic [7:0]        fexp;
    logic [3:0]        k;
    logic [OPND_W-1:0] opnd;
    logic [TAG_W-1:0]  tag;
  } item_t;

  typedef struct packed {
    kind_t             kind;
    logic              neg;
    logic [7:0]        fexp;
    logic [3:0]        k;
    logic [TAG_W-1:0]  tag;
    logic [PROD_W-1:0] prod;
  } sb_t;

  function automatic logic [POW_W-1:0] pow_ten(input logic [3:0] k);
    logic [POW_W-1:0] p;
    unique case (k)
      4'd0:    p = 30'd1;
      4'd1:    p = 30'd10;
      4'd2:    p = 30'd100;
      4'd3:    p = 30'd1000;
      4'd4:    p = 30'd10000;
      4'd5:    p = 30'd100000;
      4'd6:    p = 30'd1000000;
      4'd7:    p = 30'd10000000;
      4'd8:    p = 30'd100000000;
      4'd9:    p = 30'd1000000000;
      default: p = '0;
    endcase
    return p;
  endfunction

  // lowest possible msb of the quotient word (quotient shifted up by two)
  function automatic logic [RP_W-1:0] msb_div(input logic [3:0] k);
    logic [RP_W-1:0] m;
    unique case (k)
      4'd0:    m = 6'd58;
      4'd1:    m = 6'd54;
      4'd2:    m = 6'd51;
      4'd3:    m = 6'd48;
      4'd4:    m = 6'd44;
      4'd5:    m = 6'd41;
      4'd6:    m = 6'd38;
      4'd7:    m = 6'd34;
      4'd8:    m = 6'd31;
      4'd9:    m = 6'd28;
      default: m = 6'd28;
    endcase
    return m;
  endfunction

  // lowest possible msb of the product word (product shifted up by two)
  function automatic logic [RP_W-1:0] msb_mul(input logic [3:0] k);
    logic [RP_W-1:0] m;
    unique case (k)
      4'd0:    m = 6'd25;
      4'd1:    m = 6'd28;
      4'd2:    m = 6'd31;
      4'd3:    m = 6'd34;
      4'd4:    m = 6'd38;
      4'd5:    m = 6'd41;
      4'd6:    m = 6'd44;
      4'd7:    m = 6'd48;
      4'd8:    m = 6'd51;
      4'd9:    m = 6'd54;
      default: m = 6'd25;
    endcase
    return m;
  endfunction

endpackage

@@ hdl/meter_register_value_decoder.sv @@
// Each item passes the front register, the queue, the operand stage, the 15-stage
// divider (4 quotient bits per stage) and the finish stages to the result register.
// Throughput: one item per cycle; the whole back pipeline holds while the
// result register is stalled, the 4-entry queue absorbs the front side.
// Reset (rst_n low, synchronous): pipeline and queue empty,
// value_format = int32, word_byte_order = big endian.
module meter_register_value_decoder
  import mrvd_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // raw_bytes[31:0], scale_exponent[36:32], value_index[44:37]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // scaled_value[31:0], result_index[39:32]
  output logic        out_tuser,  // value_valid
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [1:0]  cfg_wdata
);

  fmt_t fmt_r;
  ord_t ord_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_INT32;
      ord_r <= ORD_HB_HW;
    end else if (cfg_we) begin
      if (cfg_addr == CFG_FORMAT) begin
        fmt_r <= fmt_t'(cfg_wdata);
      end
      if (cfg_addr == CFG_ORDER) begin
        ord_r <= ord_t'(cfg_wdata);
      end
    end
  end

  logic  fr_valid, fr_ready, q_full, q_empty, q_pop;
  item_t fr_item, q_item;
  logic [VAL_W-1:0] value;
  logic [TAG_W-1:0] tag;

  mrvd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .raw_bytes      (in_tdata[31:0]),
    .scale_exponent (in_tdata[36:32]),
    .value_index    (in_tdata[44:37]),
    .fmt            (fmt_r),
    .ord            (ord_r),
    .out_valid      (fr_valid),
    .out_ready      (fr_ready),
    .out_item       (fr_item)
  );

  assign fr_ready = !q_full;

  mrvd_fifo #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (fr_valid),
    .wr_item (fr_item),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_item (q_item),
    .empty   (q_empty)
  );

  mrvd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_value (value),
    .out_flag  (out_tuser),
    .out_tag   (tag)
  );

  assign out_tdata = {tag, value};

endmodule

@@ hdl/mrvd_front.sv @@
module mrvd_front
  import mrvd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [RAW_W-1:0] raw_bytes,
  input  logic [EXP_W-1:0] scale_exponent,
  input  logic [TAG_W-1:0] value_index,
  input  fmt_t             fmt,
  input  ord_t             ord,
  output logic             out_valid,
  input  logic             out_ready,
  output item_t            out_item
);

  logic  f_v_r;
  item_t f_item_r, f_item_nxt;

  logic [7:0]        b0, b1, b2, b3;
  logic [15:0]       w16;
  logic [31:0]       w32, v32, mag;
  logic signed [EXP_W-1:0] e;
  logic [EXP_W-1:0]  e_neg;
  logic              in_range;

  assign in_ready  = !f_v_r || out_ready;
  assign out_valid = f_v_r;
  assign out_item  = f_item_r;

  always_comb begin
    b0 = raw_bytes[7:0];
    b1 = raw_bytes[15:8];
    b2 = raw_bytes[23:16];
    b3 = raw_bytes[31:24];
    w16 = (ord == ORD_LB_LW || ord == ORD_LB_HW) ? {b1, b0} : {b0, b1};
    unique case (ord)
      ORD_LB_LW: w32 = {b3, b2, b1, b0};
      ORD_LB_HW: w32 = {b1, b0, b3, b2};
      ORD_HB_LW: w32 = {b2, b3, b0, b1};
      ORD_HB_HW: w32 = {b0, b1, b2, b3};
      default:   w32 = {b0, b1, b2, b3};
    endcase
    e        = $signed(scale_exponent);
    e_neg    = EXP_W'(-scale_exponent);
    in_range = (e >= -5'sd9) && (e <= 5'sd9);
    v32 = (fmt == FMT_INT16) ? {{16{w16[15]}}, w16} : w32;
    mag = v32[31] ? 32'(-v32) : v32;

    f_item_nxt.tag  = value_index;
    f_item_nxt.k    = e[EXP_W-1] ? e_neg[3:0] : scale_exponent[3:0];
    f_item_nxt.fexp = w32[30:23];
    f_item_nxt.neg  = v32[31];
    f_item_nxt.opnd = mag;
    priority if (fmt == FMT_NONE || !in_range) begin
      f_item_nxt.kind = K_INVALID;
    end else if (fmt == FMT_FLOAT32) begin
      f_item_nxt.opnd = {8'd0, 1'b1, w32[22:0]};
      if (w32[30:23] == 8'hFF) begin
        f_item_nxt.kind = K_INVALID;
      end else if (w32[30:23] == 8'h00) begin
        f_item_nxt.kind = K_ZERO;
      end else begin
        f_item_nxt.kind = e[EXP_W-1] ? K_FMUL : K_FDIV;
      end
    end else begin
      f_item_nxt.kind = e[EXP_W-1] ? K_IMUL : K_IDIV;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (in_ready) begin
      f_v_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      f_item_r <= f_item_nxt;
    end
  end

endmodule

@@ hdl/mrvd_fifo.sv @@
module mrvd_fifo
  import mrvd_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr_en,
  input  item_t wr_item,
  output logic  full,
  input  logic  rd_en,
  output item_t rd_item,
  output logic  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  item_t         mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic          do_wr, do_rd;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_item = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_rd) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      unique case ({do_wr, do_rd})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

@@ hdl/mrvd_div_stage.sv @@
module mrvd_div_stage
  import mrvd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_v,
  input  logic [REM_W-1:0]  in_rem,
  input  logic [DIVD_W-1:0] in_qd,
  input  logic [POW_W-1:0]  in_p,
  input  sb_t               in_sb,
  output logic              out_v,
  output logic [REM_W-1:0]  out_rem,
  output logic [DIVD_W-1:0] out_qd,
  output logic [POW_W-1:0]  out_p,
  output sb_t               out_sb
);

  logic              v_r;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [DIVD_W-1:0] qd_r, qd_nxt;
  logic [POW_W-1:0]  p_r;
  sb_t               sb_r;

  // restoring division, dividend bits shift out the top, quotient bits in the bottom
  always_comb begin
    logic [REM_W:0] t;
    rem_nxt = in_rem;
    qd_nxt  = in_qd;
    t       = '0;
    for (int j = 0; j < DIV_BPS; j++) begin
      t      = {rem_nxt, qd_nxt[DIVD_W-1]};
      qd_nxt = {qd_nxt[DIVD_W-2:0], 1'b0};
      if (t >= {1'b0, in_p}) begin
        t         = t - {1'b0, in_p};
        qd_nxt[0] = 1'b1;
      end
      rem_nxt = t[REM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_v;
    end
    if (en) begin
      rem_r <= rem_nxt;
      qd_r  <= qd_nxt;
      p_r   <= in_p;
      sb_r  <= in_sb;
    end
  end

  assign out_v   = v_r;
  assign out_rem = rem_r;
  assign out_qd  = qd_r;
  assign out_p   = p_r;
  assign out_sb  = sb_r;

endmodule

@@ hdl/mrvd_back.sv @@
module mrvd_back
  import mrvd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  item_t            q_item,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [VAL_W-1:0] out_value,
  output logic             out_flag,
  output logic [TAG_W-1:0] out_tag
);

  logic en;

  // operand stage: multiply and divider load
  logic              s0_v_r;
  sb_t               s0_sb_r;
  logic [POW_W-1:0]  s0_p_r;
  logic [DIVD_W-1:0] s0_divd_r;
  logic [POW_W-1:0]  p_sel;

  assign en    = !out_valid || out_ready;
  assign q_pop = en && !q_empty;
  assign p_sel = pow_ten(q_item.k);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= !q_empty;
    end
    if (en) begin
      s0_sb_r.kind <= q_item.kind;
      s0_sb_r.neg  <= q_item.neg;
      s0_sb_r.fexp <= q_item.fexp;
      s0_sb_r.k    <= q_item.k;
      s0_sb_r.tag  <= q_item.tag;
      s0_sb_r.prod <= PROD_W'(q_item.opnd) * PROD_W'(p_sel);
      s0_p_r       <= p_sel;
      s0_divd_r    <= (q_item.kind == K_FDIV) ? {3'd0, q_item.opnd[23:0], 33'd0}
                                              : DIVD_W'(q_item.opnd);
    end
  end

  logic              dv   [DIV_STAGES+1];
  logic [REM_W-1:0]  drem [DIV_STAGES+1];
  logic [DIVD_W-1:0] dqd  [DIV_STAGES+1];
  logic [POW_W-1:0]  dp   [DIV_STAGES+1];
  sb_t               dsb  [DIV_STAGES+1];

  assign dv[0]   = s0_v_r;
  assign drem[0] = '0;
  assign dqd[0]  = s0_divd_r;
  assign dp[0]   = s0_p_r;
  assign dsb[0]  = s0_sb_r;

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
    mrvd_div_stage u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_v    (dv[i]),
      .in_rem  (drem[i]),
      .in_qd   (dqd[i]),
      .in_p    (dp[i]),
      .in_sb   (dsb[i]),
      .out_v   (dv[i+1]),
      .out_rem (drem[i+1]),
      .out_qd  (dqd[i+1]),
      .out_p   (dp[i+1]),
      .out_sb  (dsb[i+1])
    );
  end

  // finish 1: pick the rounding window, integer results
  sb_t               lsb_sb;
  logic [DIVD_W-1:0] quo;
  logic [T_W-1:0]    tw;
  logic [RP_W-1:0]   m0, lp, rp, rpm1;
  logic [23:0]       win;
  logic              gbit, sticky, is_fdiv;
  logic signed [SH_W-1:0] gexp, sft;
  logic [VAL_W-1:0]  ival;
  logic              iok;

  assign lsb_sb  = dsb[DIV_STAGES];
  assign quo     = dqd[DIV_STAGES];
  assign is_fdiv = (lsb_sb.kind == K_FDIV);

  always_comb begin
    tw   = is_fdiv ? {2'd0, quo, 2'd0} : {lsb_sb.prod, 2'd0};
    m0   = is_fdiv ? msb_div(lsb_sb.k) : msb_mul(lsb_sb.k);
    lp   = tw[m0 + 1'b1] ? m0 + 1'b1 : m0;
    rp   = lp - 6'd23;
    rpm1 = rp - 1'b1;
    win  = 24'(tw >> rp);
    gbit = tw[rpm1];
    sticky = ((tw & ((64'd1 << rpm1) - 64'd1)) != '0)
             || (is_fdiv && (drem[DIV_STAGES] != '0));
    gexp = is_fdiv ? $signed({2'd0, lsb_sb.fexp}) - 10'sd185
                   : $signed({2'd0, lsb_sb.fexp}) - 10'sd152;
    sft  = $signed({4'd0, rp}) + gexp;
    ival = '0;
    iok  = 1'b0;
    unique case (lsb_sb.kind)
      K_IDIV: begin
        ival = lsb_sb.neg ? 32'(-quo[31:0]) : quo[31:0];
        iok  = 1'b1;
      end
      K_IMUL: begin
        iok  = (lsb_sb.prod <= PROD_W'(32'h7FFF_FFFF));
        ival = iok ? (lsb_sb.neg ? 32'(-lsb_sb.prod[31:0]) : lsb_sb.prod[31:0]) : '0;
      end
      K_ZERO:  iok = 1'b1;
      default: iok = 1'b0;
    endcase
  end

  logic                   f1_v_r, f1_flt_r, f1_neg_r, f1_g_r, f1_st_r, f1_ok_r;
  logic [23:0]            f1_win_r;
  logic signed [SH_W-1:0] f1_s_r;
  logic [VAL_W-1:0]       f1_ival_r;
  logic [TAG_W-1:0]       f1_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
    end else if (en) begin
      f1_v_r <= dv[DIV_STAGES];
    end
    if (en) begin
      f1_flt_r  <= is_fdiv || (lsb_sb.kind == K_FMUL);
      f1_neg_r  <= lsb_sb.neg;
      f1_g_r    <= gbit;
      f1_st_r   <= sticky;
      f1_win_r  <= win;
      f1_s_r    <= sft;
      f1_ival_r <= ival;
      f1_ok_r   <= iok;
      f1_tag_r  <= lsb_sb.tag;
    end
  end

  // finish 2: round to nearest even
  logic                   f2_v_r, f2_flt_r, f2_neg_r, f2_ok_r;
  logic [RND_W-1:0]       f2_r_r;
  logic signed [SH_W-1:0] f2_s_r;
  logic [VAL_W-1:0]       f2_ival_r;
  logic [TAG_W-1:0]       f2_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f2_v_r <= 1'b0;
    end else if (en) begin
      f2_v_r <= f1_v_r;
    end
    if (en) begin
      f2_flt_r  <= f1_flt_r;
      f2_neg_r  <= f1_neg_r;
      f2_ok_r   <= f1_ok_r;
      f2_r_r    <= {1'b0, f1_win_r}
                   + RND_W'(f1_g_r && (f1_st_r || f1_win_r[0]));
      f2_s_r    <= f1_s_r;
      f2_ival_r <= f1_ival_r;
      f2_tag_r  <= f1_tag_r;
    end
  end

  // finish 3: truncate to integer and saturate
  logic [VAL_W-1:0] fmag, fval;
  logic [SH_W-1:0]  nsh;
  logic             sat;

  always_comb begin
    nsh  = SH_W'(-f2_s_r);
    fmag = '0;
    sat  = 1'b0;
    priority if (f2_s_r >= 10'sd8) begin
      sat = 1'b1;
    end else if (f2_s_r >= 10'sd0) begin
      fmag = VAL_W'(f2_r_r) << f2_s_r[2:0];
      sat  = fmag[VAL_W-1];
    end else if (f2_s_r >= -10'sd25) begin
      fmag = VAL_W'(f2_r_r >> nsh[4:0]);
    end else begin
      fmag = '0;
    end
    if (sat) begin
      fval = f2_neg_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      fval = f2_neg_r ? 32'(-fmag) : fmag;
    end
  end

  logic             o_v_r, o_flag_r;
  logic [VAL_W-1:0] o_value_r;
  logic [TAG_W-1:0] o_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (en) begin
      o_v_r <= f2_v_r;
    end
    if (en) begin
      o_value_r <= f2_flt_r ? fval : f2_ival_r;
      o_flag_r  <= f2_flt_r || f2_ok_r;
      o_tag_r   <= f2_tag_r;
    end
  end

  assign out_valid = o_v_r;
  assign out_value = o_value_r;
  assign out_flag  = o_flag_r;
  assign out_tag   = o_tag_r;

endmodule

@@ hdl/mrvd_checker.sv @@
`include "assert_macros.svh"

module mrvd_assert (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tuser
);

  `AST_RST(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
  `AST_RST(a_invalid_zero, clk, rst_n, out_tvalid && !out_tuser |-> out_tdata[31:0] == 32'd0)
  `AST_ANY(a_reset_empty, clk, !rst_n |=> !out_tvalid)

endmodule

bind meter_register_value_decoder mrvd_assert u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

@@ verif/mrvd_checker.sv @@
`timescale 1ns / 1ps

module mrvd_checker
  import mrvd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  input  logic        out_tuser,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [1:0]  cfg_wdata,
  output int          errors,
  output int          pending
);

  typedef struct {
    logic [31:0] value;
    logic        ok;
    logic [7:0]  tag;
  } reading_t;

  fmt_t       fmt_q;
  ord_t       ord_q;
  reading_t   expected_readings[$];
  int         err_cnt = 0;

  function automatic logic [31:0] arrange_bytes(logic [31:0] raw, ord_t ord, bit is16);
    logic [7:0] b0, b1, b2, b3;
    b0 = raw[7:0];
    b1 = raw[15:8];
    b2 = raw[23:16];
    b3 = raw[31:24];
    if (is16)
      return (ord == ORD_LB_LW || ord == ORD_LB_HW) ? {16'd0, b1, b0} : {16'd0, b0, b1};
    case (ord)
      ORD_LB_LW: return {b3, b2, b1, b0};
      ORD_LB_HW: return {b1, b0, b3, b2};
      ORD_HB_LW: return {b2, b3, b0, b1};
      default:   return {b0, b1, b2, b3};
    endcase
  endfunction

  function automatic real f32_to_real(logic [31:0] f);
    logic [63:0] d;
    real         m;
    if (f[30:23] == 8'd0) begin
      m = real'(f[22:0]) * (2.0 ** -149);
      return f[31] ? -m : m;
    end
    d = {f[31], 11'(f[30:23] - 8'd127 + 11'd1023), f[22:0], 29'd0};
    if (f[30])
      d[62:52] = 11'd1023 + 11'(f[30:23] - 8'd127);
    else
      d[62:52] = 11'd1023 - 11'(8'd127 - f[30:23]);
    return $bitstoreal(d);
  endfunction

  // round a double to single precision, nearest even
  function automatic real round_single(real r);
    logic [63:0] d;
    logic [28:0] lo;
    d  = $realtobits(r);
    lo = d[28:0];
    d[28:0] = '0;
    if (lo > 29'h1000_0000 || (lo == 29'h1000_0000 && d[29]))
      d = d + 64'h2000_0000;
    return $bitstoreal(d);
  endfunction

  function automatic reading_t decode_reading(logic [31:0] raw, logic signed [4:0] e,
                                              logic [7:0] tag);
    reading_t    rd;
    int          k;
    longint      p, v, mag;
    logic [31:0] bits;
    real         r;
    rd.value = '0;
    rd.ok    = 1'b0;
    rd.tag   = tag;
    if (fmt_q == FMT_NONE || e < -9 || e > 9)
      return rd;
    k = (e >= 0) ? e : -e;
    p = 1;
    repeat (k) p = p * 10;
    if (fmt_q == FMT_FLOAT32) begin
      bits = arrange_bytes(raw, ord_q, 0);
      if (bits[30:23] == 8'hFF)
        return rd;
      r = (e >= 0) ? f32_to_real(bits) / real'(p) : f32_to_real(bits) * real'(p);
      r = round_single(r);
      if (r >= 2147483648.0)
        rd.value = 32'h7FFF_FFFF;
      else if (r < -2147483648.0)
        rd.value = 32'h8000_0000;
      else
        rd.value = 32'($rtoi(r));
      rd.ok = 1'b1;
      return rd;
    end
    if (fmt_q == FMT_INT16) begin
      bits = arrange_bytes(raw, ord_q, 1);
      v = longint'($signed(bits[15:0]));
    end else begin
      bits = arrange_bytes(raw, ord_q, 0);
      v = longint'($signed(bits));
    end
    if (e >= 0) begin
      rd.value = 32'(v / p);
      rd.ok    = 1'b1;
    end else begin
      mag = (v >= 0) ? v : -v;
      if (v == 0 || mag <= 64'sd2147483647 / p) begin
        rd.value = 32'(v * p);
        rd.ok    = 1'b1;
      end
    end
    return rd;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch %s: got %h expected %h", $realtime, what, got, want);
    err_cnt++;
  endtask

  assign pending = expected_readings.size();
  assign errors  = err_cnt;

  always @(posedge clk) begin
    reading_t want;
    if (!rst_n) begin
      fmt_q <= FMT_INT32;
      ord_q <= ORD_HB_HW;
      expected_readings.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_addr == CFG_FORMAT)
          fmt_q <= fmt_t'(cfg_wdata);
        else
          ord_q <= ord_t'(cfg_wdata);
      end
      if (in_tvalid && in_tready)
        expected_readings.push_back(decode_reading(in_tdata[31:0], in_tdata[36:32],
                                                   in_tdata[44:37]));
      if (out_tvalid && out_tready) begin
        if (expected_readings.size() == 0) begin
          report_mismatch("unexpected transfer", out_tdata[31:0], '0);
        end else begin
          want = expected_readings.pop_front();
          if (out_tdata[31:0] !== want.value)
            report_mismatch("scaled_value", out_tdata[31:0], want.value);
          if (out_tuser !== want.ok)
            report_mismatch("value_valid", 32'(out_tuser), 32'(want.ok));
          if (out_tdata[39:32] !== want.tag)
            report_mismatch("result_index", 32'(out_tdata[39:32]), 32'(want.tag));
        end
      end
    end
  end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import mrvd_pkg::*;

  localparam int IDLE_LIMIT = 3000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // raw_bytes[31:0], scale_exponent[36:32], value_index[44:37]
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // scaled_value[31:0], result_index[39:32]
  logic        out_tuser;  // value_valid
  logic        cfg_we;
  logic        cfg_addr;
  logic [1:0]  cfg_wdata;
  int          errors;
  int          pending;
  int          idle_cycles;
  int          rx_stall;
  bit          tx_busy_mode;
  bit          rx_busy_mode;
  bit          first_item;

  meter_register_value_decoder dut (.*);

  mrvd_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random stall per transfer, with bursts of no stall
  always @(posedge clk) begin
    int rx_hold;
    if (!rst_n) begin
      rx_stall     <= 0;
      rx_busy_mode <= 1'b1;
      out_tready   <= 1'b0;
    end else if (out_tvalid && out_tready) begin
      if ($urandom_range(0, 99) == 0)
        rx_busy_mode <= ~rx_busy_mode;
      if (rx_busy_mode && $urandom_range(0, 19) != 0) begin
        rx_hold = $urandom_range(0, 19);
        if (rx_hold > 0) begin
          rx_stall   <= rx_hold - 1;
          out_tready <= 1'b0;
        end
      end
    end else if (rx_stall > 0) begin
      rx_stall   <= rx_stall - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic send_reading(logic [31:0] raw, logic [4:0] e, logic [7:0] tag);
    int  gap;
    bit  hs;
    gap = (tx_busy_mode && !first_item) ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    first_item = 1'b0;
    in_tdata  <= {3'd0, tag, e, raw};
    in_tvalid <= 1'b1;
    do begin
      @(negedge clk);
      hs = in_tready;
      @(posedge clk);
    end while (!hs);
    if ($urandom_range(0, 99) == 0)
      tx_busy_mode = ~tx_busy_mode;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    first_item = 1'b1;
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(logic addr, logic [1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [31:0] pick_raw();
    logic [31:0] raw;
    logic [7:0]  base;
    int          pos;
    case ($urandom_range(0, 5))
      0: raw = $urandom;
      1: begin
        base = 8'h3C + 8'($urandom_range(0, 19));
        for (int i = 0; i < 4; i++)
          raw[i*8 +: 8] = {1'($urandom), base[6:0]} ^ 8'($urandom_range(0, 1));
      end
      2: begin
        pos = $urandom_range(0, 3);
        raw = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
        raw[pos*8 +: 8] = 8'($urandom);
      end
      3: raw = {4{8'($urandom_range(0, 1) ? 8'hFF : 8'h00)}};
      4: begin
        raw = $urandom;
        for (int i = 0; i < 4; i++)
          if ($urandom_range(0, 1)) raw[i*8 +: 8] = {raw[i*8+7], 7'h7F};
      end
      default: raw = $urandom & {4{8'($urandom_range(0, 1) ? 8'h80 : 8'h01)}};
    endcase
    return raw;
  endfunction

  initial begin
    logic [4:0] e;
    logic [1:0] fmt_sel, ord_sel;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    cfg_we       = 1'b0;
    cfg_addr     = CFG_FORMAT;
    cfg_wdata    = '0;
    tx_busy_mode = 1'b1;
    first_item   = 1'b1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset config: int32 big endian
    send_reading(32'h0000_0000, 5'd0, 8'h00);
    send_reading(32'hFFFF_FFFF, 5'd9, 8'hFF);
    send_reading(32'h0000_0080, 5'h1F, 8'h01);
    send_reading(32'hFFFF_FF7F, 5'd0, 8'h02);
    send_reading(32'hFFFF_FF7F, 5'h1F, 8'h03);
    send_reading(32'h0100_0000, 5'h17, 8'h04);
    send_reading(32'h0100_0000, 5'h10, 8'h05);
    send_reading(32'h0000_0000, 5'h10, 8'h06);
    send_reading(32'h1000_0000, 5'd10, 8'h07);
    send_reading(32'hF9FF_FFFF, 5'd1, 8'h08);
    send_reading(32'h4D02_0000, 5'h17, 8'h09);
    send_reading(32'h4E02_0000, 5'h17, 8'h0A);
    drain();
    write_reg(CFG_FORMAT, FMT_FLOAT32);
    send_reading(32'h0000_807F, 5'd0, 8'h10);
    send_reading(32'h0000_C07F, 5'd0, 8'h11);
    send_reading(32'h0000_80FF, 5'd3, 8'h12);
    send_reading(32'hFFFF_7F7F, 5'h17, 8'h13);
    send_reading(32'h0000_00CF, 5'd0, 8'h14);
    send_reading(32'h0000_004F, 5'd0, 8'h15);
    send_reading(32'h0000_C03F, 5'd1, 8'h16);
    send_reading(32'h0000_803F, 5'h1F, 8'h17);
    drain();
    write_reg(CFG_FORMAT, FMT_INT16);
    write_reg(CFG_ORDER, ORD_LB_LW);
    send_reading(32'h1234_8000, 5'h17, 8'h20);
    send_reading(32'h0000_7FFF, 5'h1B, 8'h21);
    send_reading(32'h0000_7FFF, 5'h1C, 8'h22);
    drain();

    for (int phase = 0; phase < 16; phase++) begin
      fmt_sel = (phase == 15) ? FMT_INT32 : 2'($urandom_range(0, 3));
      ord_sel = (phase == 15) ? ORD_HB_HW : 2'($urandom_range(0, 3));
      if (phase < 8) begin
        fmt_sel = 2'(phase / 2);
        ord_sel = 2'(phase);
      end
      write_reg(CFG_FORMAT, fmt_sel);
      write_reg(CFG_ORDER, ord_sel);
      for (int n = 0; n < 70; n++) begin
        if ($urandom_range(0, 9) == 0)
          e = 5'($urandom);
        else
          e = 5'($signed($urandom_range(0, 18)) - 9);
        send_reading(pick_raw(), e, 8'($urandom));
        if (phase == 4 && n == 35)
          drain();
      end
      drain();
    end

    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ meter_register_value_decoder.f @@
+incdir+hdl
hdl/mrvd_pkg.sv
hdl/mrvd_front.sv
hdl/mrvd_fifo.sv
hdl/mrvd_div_stage.sv
hdl/mrvd_back.sv
hdl/meter_register_value_decoder.sv
hdl/mrvd_checker.sv
verif/mrvd_checker.sv
verif/tb_top.sv
